// ===== design/eqf_pkg.sv =====
// shared constants, codes and types for the three-band fir equalizer
package eqf_pkg;

  localparam int EQF_TAP_COUNT = 882;

  localparam logic [15:0] GAIN_LOW_RST  = 16'd22938;
  localparam logic [15:0] GAIN_HIGH_RST = 16'd16384;
  localparam logic [15:0] GAIN_MID_RST  = 16'd19661;

  localparam int CFG_INDEX_W = 2;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 16;
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int GAIN_W      = 16;
  localparam int TAP_W       = 10;
  localparam int BAND_W      = 2;
  localparam int BANDS       = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_MID  = 2'd2;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_HIGH = 2'd1;
  localparam logic [BAND_W-1:0] BAND_MID  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } eqf_state_t;

  // one tap beat travelling from the sequencer into the mac pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic live;
  } eqf_tap_ctl_t;

endpackage

// ===== design/eqf_coef_mem.sv =====
// coefficient memory, one entry per tap holding the three band coefficients
module eqf_coef_mem #(
  parameter int TAP_COUNT = eqf_pkg::EQF_TAP_COUNT,
  parameter int ADDR_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
  input  logic clk,
  input  logic [eqf_pkg::BANDS-1:0] we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [eqf_pkg::COEF_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [eqf_pkg::BANDS*eqf_pkg::COEF_W-1:0] rdata
);
  import eqf_pkg::*;

  logic [BANDS*COEF_W-1:0] mem [TAP_COUNT];

  always_ff @(posedge clk) begin
    for (int b = 0; b < BANDS; b++) begin
      if (we[b]) begin
        mem[waddr][b*COEF_W +: COEF_W] <= wdata;
      end
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/eqf_delay_mem.sv =====
// circular sample delay line memory
module eqf_delay_mem #(
  parameter int TAP_COUNT = eqf_pkg::EQF_TAP_COUNT,
  parameter int ADDR_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
  input  logic clk,
  input  logic we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [eqf_pkg::SAMPLE_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [eqf_pkg::SAMPLE_W-1:0] rdata
);
  import eqf_pkg::*;

  logic [SAMPLE_W-1:0] mem [TAP_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/eqf_mac.sv =====
// multiply, gain scale and accumulate pipeline with truncation and saturation
module eqf_mac #(
  parameter int TAP_COUNT = eqf_pkg::EQF_TAP_COUNT,
  parameter int ADDR_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
  input  logic clk,
  input  logic rst,
  input  eqf_pkg::eqf_tap_ctl_t ctl,
  input  logic [eqf_pkg::BANDS*eqf_pkg::COEF_W-1:0] coef_rdata,
  input  logic [eqf_pkg::SAMPLE_W-1:0] dly_rdata,
  input  logic [eqf_pkg::BANDS-1:0][eqf_pkg::GAIN_W-1:0] gains,
  output logic acc_done,
  output logic [eqf_pkg::SAMPLE_W-1:0] result,
  output logic clip
);
  import eqf_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int SC_W = PROD_W + GAIN_W;
  localparam int SUM_W = SC_W + 2;
  localparam int ACC_W = SUM_W + ADDR_W;
  localparam int FRAC = 30;
  localparam int Q_W = ACC_W - FRAC;

  eqf_tap_ctl_t ctl_r;
  eqf_tap_ctl_t ctl_p;
  eqf_tap_ctl_t ctl_g;
  eqf_tap_ctl_t ctl_s;

  logic signed [PROD_W-1:0] prod [BANDS];
  logic signed [SC_W-1:0] scaled [BANDS];
  logic signed [SC_W:0] sc_full [BANDS];
  logic signed [SUM_W-1:0] sum3;
  logic signed [ACC_W-1:0] acc;
  logic signed [SAMPLE_W-1:0] smp;
  logic [Q_W-1:0] q_floor;
  logic [Q_W-1:0] q;
  logic adj;
  logic sat_hi;
  logic sat_lo;

  assign smp = ctl_r.live ? $signed(dly_rdata) : '0;

  always_comb begin
    for (int b = 0; b < BANDS; b++) begin
      sc_full[b] = prod[b] * $signed({1'b0, gains[b]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_r <= '0;
      ctl_p <= '0;
      ctl_g <= '0;
      ctl_s <= '0;
      acc_done <= 1'b0;
    end else begin
      ctl_r <= ctl;
      ctl_p <= ctl_r;
      ctl_g <= ctl_p;
      ctl_s <= ctl_g;
      acc_done <= ctl_s.valid && ctl_s.last;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < BANDS; b++) begin
      prod[b] <= $signed(coef_rdata[b*COEF_W +: COEF_W]) * smp;
      scaled[b] <= sc_full[b][SC_W-1:0];
    end
    sum3 <= SUM_W'(scaled[0]) + SUM_W'(scaled[1]) + SUM_W'(scaled[2]);
    if (ctl_s.valid) begin
      if (ctl_s.first) begin
        acc <= ACC_W'(sum3);
      end else begin
        acc <= acc + ACC_W'(sum3);
      end
    end
  end

  // divide by 2^30 toward zero, then clamp to 16 bits
  assign q_floor = acc[ACC_W-1:FRAC];
  assign adj = acc[ACC_W-1] && (acc[FRAC-1:0] != '0);
  assign q = q_floor + Q_W'(adj);
  assign sat_hi = !q[Q_W-1] && (q[Q_W-2:SAMPLE_W-1] != '0);
  assign sat_lo = q[Q_W-1] && (q[Q_W-2:SAMPLE_W-1] != '1);
  assign clip = sat_hi || sat_lo;

  always_comb begin
    if (sat_hi) begin
      result = 16'h7fff;
    end else if (sat_lo) begin
      result = 16'h8000;
    end else begin
      result = q[SAMPLE_W-1:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    acc_done |-> !ctl_s.valid && !ctl_g.valid)
    else $error("accumulator done while taps still in flight");

  assert property (@(posedge clk) disable iff (rst)
    ctl_s.valid && !ctl_s.first |-> $past(ctl_s.valid))
    else $error("tap beat accumulated without a preceding beat");

  assert property (@(posedge clk) disable iff (rst)
    ctl_r.valid && ctl_r.first |-> !ctl_s.valid || ctl_s.last)
    else $error("new sample entered while previous sum not closed");

endmodule

// ===== design/eqf_seq.sv =====
// sequencer: takes input beats, writes memories and walks the taps
module eqf_seq #(
  parameter int TAP_COUNT = eqf_pkg::EQF_TAP_COUNT,
  parameter int ADDR_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic cmd,
  input  logic [eqf_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [eqf_pkg::BAND_W-1:0] band,
  input  logic [eqf_pkg::TAP_W-1:0] tap,
  output logic [eqf_pkg::BANDS-1:0] coef_we,
  output logic [ADDR_W-1:0] coef_waddr,
  output logic [ADDR_W-1:0] coef_raddr,
  output logic dly_we,
  output logic [ADDR_W-1:0] dly_waddr,
  output logic [eqf_pkg::SAMPLE_W-1:0] dly_wdata,
  output logic [ADDR_W-1:0] dly_raddr,
  output eqf_pkg::eqf_tap_ctl_t ctl,
  input  logic acc_done,
  input  logic out_free,
  output logic out_load
);
  import eqf_pkg::*;

  localparam int CNT_W = $clog2(TAP_COUNT + 1);
  localparam int EXT_W = ((ADDR_W > TAP_W) ? ADDR_W : TAP_W) + 1;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TAP_COUNT - 1);

  eqf_state_t state;
  eqf_state_t state_next;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] dptr;
  logic [ADDR_W-1:0] wptr;
  logic [CNT_W-1:0] fill;
  logic [EXT_W-1:0] tap_x;
  logic tap_ok;
  logic accept;
  logic is_last;

  assign accept = s_tvalid && s_tready;
  assign tap_x = EXT_W'(tap);
  assign tap_ok = tap_x < EXT_W'(TAP_COUNT);
  assign is_last = idx == LAST;

  assign coef_waddr = tap_x[ADDR_W-1:0];
  assign coef_raddr = idx;
  assign dly_waddr = wptr;
  assign dly_wdata = sample_in;
  assign dly_raddr = dptr;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_SAMPLE) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (is_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (acc_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    coef_we = '0;
    dly_we = 1'b0;
    ctl = '0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && cmd == CMD_SAMPLE) begin
          dly_we = 1'b1;
        end
        if (s_tvalid && cmd == CMD_LOAD && tap_ok) begin
          case (band)
            BAND_LOW: coef_we[0] = 1'b1;
            BAND_HIGH: coef_we[1] = 1'b1;
            BAND_MID: coef_we[2] = 1'b1;
            default: coef_we = '0;
          endcase
        end
      end
      ST_RUN: begin
        ctl.valid = 1'b1;
        ctl.first = idx == '0;
        ctl.last = is_last;
        ctl.live = CNT_W'(idx) < fill;
      end
      ST_DRAIN: begin
        out_load = 1'b0;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      dptr <= '0;
      wptr <= '0;
      fill <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept && cmd == CMD_SAMPLE) begin
        idx <= '0;
        dptr <= wptr;
        if (fill != CNT_W'(TAP_COUNT)) begin
          fill <= fill + CNT_W'(1);
        end
      end
      if (state == ST_RUN) begin
        idx <= idx + ADDR_W'(1);
        dptr <= (dptr == '0) ? LAST : dptr - ADDR_W'(1);
        if (is_last) begin
          wptr <= (wptr == LAST) ? '0 : wptr + ADDR_W'(1);
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !dly_we && coef_we == '0)
    else $error("memory write while taps are being read");

  assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(TAP_COUNT) && wptr <= LAST && dptr <= LAST)
    else $error("delay line pointer or fill count out of range");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && is_last |=> state == ST_DRAIN && !ctl.valid)
    else $error("tap walk did not close after the last tap");

endmodule

// ===== design/three_band_fir_equalizer_core.sv =====
// top level of the three-band fir graphic equalizer
//
// input stream s_*: tuser carries the command, 0 for a sample beat and 1 for
// a coefficient load beat. a load beat writes one coefficient and gives no
// result; a load for band three or a tap at or beyond TAP_COUNT is
// dropped. a sample beat gives exactly one beat on m_*.
// the three band gains sit behind the cfg_* write port (index 0 low,
// 1 high, 2 mid; other indexes are ignored), always ready; the user must
// write them only while the block is idle; the block does not enforce it.
// a sample walks all taps at one tap per cycle, the three bands side by
// side, limited by the single read port of the coefficient and delay line
// memories; the next beat is taken in the cycle after the result is loaded.
// reset clears the fill count of the delay line, so unwritten delay
// entries read as zero without a clearing pass; gains return to 0.7, 0.5
// and 0.6. coefficients are undefined until loaded.
// if the receiver stalls, the result waits in the output register and the
// block still takes the next beat; a second result waits in the sequencer
// until the output register is free.
module three_band_fir_equalizer_core #(
  parameter int TAP_COUNT = eqf_pkg::EQF_TAP_COUNT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // sample_in[15:0], band[17:16], tap[27:18], coef_value[43:28], zero pad
  input  logic [eqf_pkg::IN_DATA_W-1:0] s_tdata,
  // command[0]
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // sample_out[15:0]
  output logic [eqf_pkg::OUT_DATA_W-1:0] m_tdata,
  // clipped[0]
  output logic m_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [eqf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [eqf_pkg::GAIN_W-1:0] cfg_data
);
  import eqf_pkg::*;

  localparam int ADDR_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

  logic [GAIN_W-1:0] gain_low;
  logic [GAIN_W-1:0] gain_high;
  logic [GAIN_W-1:0] gain_mid;
  logic [BANDS-1:0][GAIN_W-1:0] gains;

  logic [BANDS-1:0] coef_we;
  logic [ADDR_W-1:0] coef_waddr;
  logic [ADDR_W-1:0] coef_raddr;
  logic [BANDS*COEF_W-1:0] coef_rdata;
  logic dly_we;
  logic [ADDR_W-1:0] dly_waddr;
  logic [SAMPLE_W-1:0] dly_wdata;
  logic [ADDR_W-1:0] dly_raddr;
  logic [SAMPLE_W-1:0] dly_rdata;
  eqf_tap_ctl_t ctl;
  logic acc_done;
  logic [SAMPLE_W-1:0] result;
  logic clip;
  logic out_free;
  logic out_load;

  assign cfg_ready = 1'b1;
  assign gains[0] = gain_low;
  assign gains[1] = gain_high;
  assign gains[2] = gain_mid;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_low <= GAIN_LOW_RST;
      gain_high <= GAIN_HIGH_RST;
      gain_mid <= GAIN_MID_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_LOW: gain_low <= cfg_data;
        REG_GAIN_HIGH: gain_high <= cfg_data;
        REG_GAIN_MID: gain_mid <= cfg_data;
        default: gain_low <= gain_low;
      endcase
    end
  end

  eqf_seq #(
    .TAP_COUNT(TAP_COUNT),
    .ADDR_W(ADDR_W)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .cmd(s_tuser),
    .sample_in(s_tdata[15:0]),
    .band(s_tdata[17:16]),
    .tap(s_tdata[27:18]),
    .coef_we(coef_we),
    .coef_waddr(coef_waddr),
    .coef_raddr(coef_raddr),
    .dly_we(dly_we),
    .dly_waddr(dly_waddr),
    .dly_wdata(dly_wdata),
    .dly_raddr(dly_raddr),
    .ctl(ctl),
    .acc_done(acc_done),
    .out_free(out_free),
    .out_load(out_load)
  );

  eqf_coef_mem #(
    .TAP_COUNT(TAP_COUNT),
    .ADDR_W(ADDR_W)
  ) u_coef_mem (
    .clk(clk),
    .we(coef_we),
    .waddr(coef_waddr),
    .wdata(s_tdata[43:28]),
    .raddr(coef_raddr),
    .rdata(coef_rdata)
  );

  eqf_delay_mem #(
    .TAP_COUNT(TAP_COUNT),
    .ADDR_W(ADDR_W)
  ) u_delay_mem (
    .clk(clk),
    .we(dly_we),
    .waddr(dly_waddr),
    .wdata(dly_wdata),
    .raddr(dly_raddr),
    .rdata(dly_rdata)
  );

  eqf_mac #(
    .TAP_COUNT(TAP_COUNT),
    .ADDR_W(ADDR_W)
  ) u_mac (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .coef_rdata(coef_rdata),
    .dly_rdata(dly_rdata),
    .gains(gains),
    .acc_done(acc_done),
    .result(result),
    .clip(clip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= result;
      m_tuser <= clip;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result loaded over a beat not yet taken");

  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !out_load && !ctl.valid)
    else $error("input taken while a sample is in progress");

  assert property (@(posedge clk) disable iff (rst)
    acc_done |=> !s_tready)
    else $error("sequencer idle before the result was loaded");

endmodule

// ===== test/eq_output_checker.sv =====
// output checker for the three-band fir equalizer: tracks gains, coefficients and delay line
module eq_output_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [eqf_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [eqf_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            m_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [eqf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [eqf_pkg::GAIN_W-1:0]      cfg_data,
  output int                              errors,
  output int                              pending
);
  import eqf_pkg::*;

  localparam longint Q30_ONE = 64'sd1073741824;

  typedef struct {
    logic [SAMPLE_W-1:0] pcm;
    logic                clip;
  } eq_result_t;

  eq_result_t                 awaited_q[$];
  logic [GAIN_W-1:0]          band_gain [BANDS];
  logic signed [SAMPLE_W-1:0] history [EQF_TAP_COUNT];
  logic signed [COEF_W-1:0]   coef [BANDS][EQF_TAP_COUNT];
  int                         fail_count = 0;

  // shift the new sample in, then weigh each band's dot product by its gain
  function automatic eq_result_t equalize(input logic signed [SAMPLE_W-1:0] pcm);
    longint     acc;
    longint     total;
    longint     whole;
    eq_result_t r;
    for (int i = EQF_TAP_COUNT - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = pcm;
    total = 0;
    for (int b = 0; b < BANDS; b++) begin
      acc = 0;
      for (int i = 0; i < EQF_TAP_COUNT; i++)
        acc += longint'(coef[b][i]) * longint'(history[i]);
      total += acc * longint'(band_gain[b]);
    end
    whole = total / Q30_ONE;
    r.clip = 1'b1;
    if (whole > 32767) r.pcm = 16'h7fff;
    else if (whole < -32768) r.pcm = 16'h8000;
    else begin
      r.pcm  = SAMPLE_W'(whole);
      r.clip = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    eq_result_t               want;
    logic [BAND_W-1:0]        ld_band;
    logic [TAP_W-1:0]         ld_tap;
    if (rst) begin
      band_gain[BAND_LOW]  = GAIN_LOW_RST;
      band_gain[BAND_HIGH] = GAIN_HIGH_RST;
      band_gain[BAND_MID]  = GAIN_MID_RST;
      foreach (history[i]) history[i] = '0;
      awaited_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_LOW:  band_gain[BAND_LOW]  = cfg_data;
          REG_GAIN_HIGH: band_gain[BAND_HIGH] = cfg_data;
          REG_GAIN_MID:  band_gain[BAND_MID]  = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (awaited_q.size() == 0) begin
          $error("sample_out: no beat expected, got %0d", $signed(m_tdata));
          fail_count++;
        end else begin
          want = awaited_q.pop_front();
          if (m_tdata !== want.pcm) begin
            $error("sample_out: expected %0d, actual %0d", $signed(want.pcm), $signed(m_tdata));
            fail_count++;
          end
          if (m_tuser !== want.clip) begin
            $error("clipped: expected %0b, actual %0b", want.clip, m_tuser);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_SAMPLE) begin
          awaited_q.push_back(equalize(s_tdata[15:0]));
        end else begin
          ld_band = s_tdata[17:16];
          ld_tap  = s_tdata[27:18];
          // band three and taps past the end are dropped
          if (ld_band <= BAND_MID && ld_tap < EQF_TAP_COUNT)
            coef[ld_band][ld_tap] = s_tdata[43:28];
        end
      end
    end
    errors  <= fail_count;
    pending <= awaited_q.size();
  end

endmodule

// ===== test/three_band_fir_equalizer_core_tb.sv =====
// testbench top for the three-band fir equalizer: stimulus, handshake idling and verdict
module three_band_fir_equalizer_core_tb;
  import eqf_pkg::*;

  localparam int SETTLE         = EQF_TAP_COUNT + 24;
  localparam int WATCHDOG_LIMIT = 8 * (EQF_TAP_COUNT + 16);
  localparam int RANDOM_BEATS   = 165;
  localparam int LAST_TAP       = EQF_TAP_COUNT - 1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [BAND_W-1:0]      BAND_NONE  = 2'd3;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata   = '0;
  logic                   s_tuser   = CMD_SAMPLE;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_GAIN_LOW;
  logic [GAIN_W-1:0]      cfg_data  = '0;

  int errors;
  int pending;
  int send_idle = 0;
  int recv_idle = 0;
  int quiet     = 0;

  three_band_fir_equalizer_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  eq_output_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] rand_word(input int spread);
    logic [15:0] w;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: w = 16'($urandom_range(2 * spread) - spread);
      6, 7:             w = 16'($urandom);
      8:                w = $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default:          w = '0;
    endcase
    return w;
  endfunction

  // unused fields of each beat carry random noise
  function automatic logic [IN_DATA_W-1:0] sample_beat(input logic [SAMPLE_W-1:0] pcm);
    logic [IN_DATA_W-1:0] d;
    d        = '0;
    d[15:0]  = pcm;
    d[17:16] = BAND_W'($urandom);
    d[27:18] = TAP_W'($urandom);
    d[43:28] = COEF_W'($urandom);
    return d;
  endfunction

  function automatic logic [IN_DATA_W-1:0] load_beat(input logic [BAND_W-1:0] band,
                                                     input logic [TAP_W-1:0] tap,
                                                     input logic [COEF_W-1:0] value);
    logic [IN_DATA_W-1:0] d;
    d        = '0;
    d[15:0]  = SAMPLE_W'($urandom);
    d[17:16] = band;
    d[27:18] = tap;
    d[43:28] = value;
    return d;
  endfunction

  task automatic send(input logic cmd, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // hold off until every result is out and the block has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // every coefficient gets written first, sparse taps keep sums in range
    for (int b = 0; b < BANDS; b++)
      for (int t = 0; t < EQF_TAP_COUNT; t++)
        send(CMD_LOAD, load_beat(BAND_W'(b), TAP_W'(t),
             (t < 8 || t == LAST_TAP) ? 16'($urandom_range(8191) - 4096) : 16'h0000));

    // directed beats under the reset gains
    send(CMD_SAMPLE, sample_beat(16'h7fff));
    send(CMD_SAMPLE, sample_beat(16'h8000));
    send(CMD_SAMPLE, sample_beat(16'h0001));
    send(CMD_SAMPLE, sample_beat(16'hffff));
    send(CMD_SAMPLE, sample_beat(16'h0000));
    send(CMD_LOAD, load_beat(BAND_NONE, 10'd3, 16'h7fff));
    send(CMD_LOAD, load_beat(BAND_LOW, 10'd1023, 16'h8000));
    send(CMD_LOAD, load_beat(BAND_HIGH, TAP_W'(EQF_TAP_COUNT), 16'h7fff));
    send(CMD_LOAD, load_beat(BAND_LOW, 10'd0, 16'h7fff));
    send(CMD_LOAD, load_beat(BAND_HIGH, 10'd0, 16'h7fff));
    send(CMD_LOAD, load_beat(BAND_MID, 10'd0, 16'h7fff));
    send(CMD_LOAD, load_beat(BAND_HIGH, TAP_W'(LAST_TAP), 16'h8000));
    send(CMD_SAMPLE, sample_beat(16'h7fff));
    send(CMD_SAMPLE, sample_beat(16'h8000));
    send(CMD_SAMPLE, sample_beat(16'h7fff));
    send(CMD_SAMPLE, sample_beat(16'h0000));
    send(CMD_SAMPLE, sample_beat(16'h8000));
    send(CMD_LOAD, load_beat(BAND_LOW, 10'd0, 16'h8000));
    send(CMD_LOAD, load_beat(BAND_HIGH, 10'd0, 16'h8000));
    send(CMD_LOAD, load_beat(BAND_MID, 10'd0, 16'h0000));
    send(CMD_SAMPLE, sample_beat(16'h7fff));
    send(CMD_SAMPLE, sample_beat(16'h8000));
    send(CMD_SAMPLE, sample_beat(16'h0123));

    for (int ph = 0; ph < 3; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_GAIN_LOW, GAIN_W'($urandom));
          write_reg(REG_GAIN_HIGH, GAIN_W'($urandom));
          write_reg(REG_GAIN_MID, GAIN_W'($urandom));
          write_reg(REG_UNUSED, 16'hffff);
          send_idle = 10;
          recv_idle = 84;
        end
        1: begin
          write_reg(REG_GAIN_LOW, 16'hffff);
          write_reg(REG_GAIN_HIGH, 16'hffff);
          write_reg(REG_GAIN_MID, 16'h0000);
          send_idle = 84;
          recv_idle = 10;
        end
        default: begin
          write_reg(REG_GAIN_LOW, 16'h0000);
          write_reg(REG_GAIN_HIGH, GAIN_W'($urandom));
          write_reg(REG_GAIN_MID, 16'hffff);
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      cfg_valid <= 1'b0;
      repeat (RANDOM_BEATS) begin
        if ($urandom_range(99) < 55)
          send(CMD_SAMPLE, sample_beat(rand_word(4096)));
        else
          send(CMD_LOAD, load_beat(BAND_W'($urandom_range(3)),
               ($urandom_range(99) < 85) ? TAP_W'($urandom_range(LAST_TAP))
                                         : TAP_W'($urandom_range(1023, EQF_TAP_COUNT)),
               rand_word(256)));
      end
    end

    settle();
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
